### design/ssb_pkg.sv
package ssb_pkg;

  localparam int MAX_SPRITES      = 64;
  localparam int VERTS_PER_SPRITE = 6;
  localparam int IDX_W            = $clog2(MAX_SPRITES);
  localparam int CNT_W            = $clog2(MAX_SPRITES + 1);
  localparam int TEX_W            = 32;
  localparam int DEPTH_W          = 32;
  localparam int VTX_W            = 9;
  localparam int MODE_W           = 2;

  // Sort modes as written into the mode register.
  localparam logic [MODE_W-1:0] MODE_DEPTH_ASC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEPTH_DESC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TEXTURE    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESET      = MODE_TEXTURE;

  // Register byte address of the sort mode register.
  localparam logic [2:0] ADDR_SORT_MODE = 3'd0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             insert;
    logic             load;
    logic             first;
    logic             final_item;
    logic             overflow;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] pos;
  } ssb_cmd_t;

endpackage

### design/sprite_sort_and_batch.sv
// Sprite sort and batch unit.
// Sprites arrive on the s_axis channel (texture id and depth in tdata, tlast on
// the final sprite of a set). Each is placed into a sorted row of cells as it
// arrives, one transaction per cycle, so s_axis_tready stays high while a set
// is collected. The row holds 64 sprites; further sprites are dropped and the
// overflow flag is raised on every result of that set.
// After the transaction carrying tlast, the emit state loads the first result
// into the output register; the set then drains from the bottom of the row at
// one result per cycle while the receiver accepts them. s_axis_tready
// is low during emission and returns high once the last result has entered the
// output register. A stalled receiver holds the output register and the row in
// place; nothing is lost. The sort mode register sits at address 0 of the APB
// port and must be written only while the unit is idle.
// Reset empties the set, drops m_axis_tvalid and selects texture order.
module sprite_sort_and_batch
  import ssb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // texture_id[31:0], depth[63:32]
  input  logic        s_axis_tlast,   // last_sprite
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // sprite_index[5:0], sprite_texture[37:6], vertex_offset[46:38],
  // batch_vertices[55:47]
  output logic [55:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // starts_batch[0], ends_batch[1], overflow[2]
  output logic        m_axis_tlast,   // last_result
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ssb_cmd_t          cmd;
  logic [MODE_W-1:0] sort_mode;
  logic [IDX_W-1:0]  out_index;
  logic [TEX_W-1:0]  out_texture;
  logic [VTX_W-1:0]  out_vertex_offset;
  logic [VTX_W-1:0]  out_batch_vertices;
  logic              out_starts;
  logic              out_ends;
  logic              out_overflow;
  logic              out_last;

  // Configuration register.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      sort_mode <= MODE_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == ADDR_SORT_MODE[2]) begin
      sort_mode <= pwdata[MODE_W-1:0];
    end
  end
  assign prdata = (paddr[2] == ADDR_SORT_MODE[2]) ? {{(32-MODE_W){1'b0}}, sort_mode} : '0;

  ssb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  ssb_datapath u_datapath (
    .clk                (clk),
    .cmd                (cmd),
    .sort_mode          (sort_mode),
    .in_texture         (s_axis_tdata[31:0]),
    .in_depth           (s_axis_tdata[63:32]),
    .out_index          (out_index),
    .out_texture        (out_texture),
    .out_vertex_offset  (out_vertex_offset),
    .out_batch_vertices (out_batch_vertices),
    .out_starts         (out_starts),
    .out_ends           (out_ends),
    .out_overflow       (out_overflow),
    .out_last           (out_last)
  );

  assign m_axis_tdata = {out_batch_vertices, out_vertex_offset, out_texture, out_index};
  assign m_axis_tuser = {out_overflow, out_ends, out_starts};
  assign m_axis_tlast = out_last;

endmodule

### design/ssb_datapath.sv
module ssb_datapath
  import ssb_pkg::*;
(
  input  logic                clk,
  input  ssb_cmd_t            cmd,
  input  logic [MODE_W-1:0]   sort_mode,
  input  logic [TEX_W-1:0]    in_texture,
  input  logic [DEPTH_W-1:0]  in_depth,
  output logic [IDX_W-1:0]    out_index,
  output logic [TEX_W-1:0]    out_texture,
  output logic [VTX_W-1:0]    out_vertex_offset,
  output logic [VTX_W-1:0]    out_batch_vertices,
  output logic                out_starts,
  output logic                out_ends,
  output logic                out_overflow,
  output logic                out_last
);

  // Row of sorted cells; cell i is occupied when i < count.
  logic [31:0]      cell_key [MAX_SPRITES];
  logic [TEX_W-1:0] cell_tex [MAX_SPRITES];
  logic [IDX_W-1:0] cell_idx [MAX_SPRITES];

  logic [31:0]            new_key;
  logic [MAX_SPRITES-1:0] gt;
  logic [TEX_W-1:0]       prev_tex;
  logic [CNT_W-1:0]       run_len;
  logic [CNT_W-1:0]       run_len_next;
  logic                   starts;
  logic                   ends;

  // Map every mode onto one unsigned ascending key; equal keys keep arrival order.
  always_comb begin
    unique case (sort_mode)
      MODE_DEPTH_ASC:  new_key = in_depth ^ 32'h8000_0000;
      MODE_DEPTH_DESC: new_key = ~(in_depth ^ 32'h8000_0000);
      MODE_TEXTURE:    new_key = in_texture;
      default:         new_key = '0;
    endcase
  end

  // Each occupied cell compares its key with the arriving one.
  always_comb begin
    for (int i = 0; i < MAX_SPRITES; i++) begin
      gt[i] = (CNT_W'(i) < cmd.count) && (cell_key[i] > new_key);
    end
  end

  // Insert shifts the larger cells up; emission shifts the row down by one.
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      for (int i = 0; i < MAX_SPRITES; i++) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          cell_key[i] <= cell_key[(i > 0) ? i - 1 : 0];
          cell_tex[i] <= cell_tex[(i > 0) ? i - 1 : 0];
          cell_idx[i] <= cell_idx[(i > 0) ? i - 1 : 0];
        end else if (gt[i] || CNT_W'(i) == cmd.count) begin
          cell_key[i] <= new_key;
          cell_tex[i] <= in_texture;
          cell_idx[i] <= cmd.count[IDX_W-1:0];
        end
      end
    end else if (cmd.load) begin
      for (int i = 0; i < MAX_SPRITES - 1; i++) begin
        cell_key[i] <= cell_key[i + 1];
        cell_tex[i] <= cell_tex[i + 1];
        cell_idx[i] <= cell_idx[i + 1];
      end
    end
  end

  // Batch boundaries look at the previous emitted texture and the next cell.
  assign starts       = cmd.first || (cell_tex[0] != prev_tex);
  assign ends         = cmd.final_item || (cell_tex[0] != cell_tex[1]);
  assign run_len_next = starts ? CNT_W'(1) : run_len + CNT_W'(1);

  // Output register and batch bookkeeping.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prev_tex           <= cell_tex[0];
      run_len            <= run_len_next;
      out_index          <= cell_idx[0];
      out_texture        <= cell_tex[0];
      out_vertex_offset  <= VTX_W'(cmd.pos) * VTX_W'(VERTS_PER_SPRITE);
      out_batch_vertices <= ends ? VTX_W'(VTX_W'(run_len_next) * VTX_W'(VERTS_PER_SPRITE))
                                 : '0;
      out_starts         <= starts;
      out_ends           <= ends;
      out_overflow       <= cmd.overflow;
      out_last           <= cmd.final_item;
    end
  end

endmodule

### design/ssb_ctrl.sv
module ssb_ctrl
  import ssb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ssb_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_COLLECT = 2'b01,
    S_EMIT    = 2'b10
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] pos;
  logic             dropped;
  logic             accept;
  logic             full;
  logic             load;

  assign full     = (count == CNT_W'(MAX_SPRITES));
  assign in_ready = (state == S_COLLECT);
  assign accept   = in_valid && in_ready;
  assign load     = (state == S_EMIT) && (!out_valid || out_ready);

  assign cmd.insert     = accept && !full;
  assign cmd.load       = load;
  assign cmd.first      = (pos == '0);
  assign cmd.final_item = (count == CNT_W'(1));
  assign cmd.overflow   = dropped;
  assign cmd.count      = count;
  assign cmd.pos        = pos;

  // Phase sequencing and sprite count.
  always_comb begin
    state_next = state;
    count_next = count;
    unique case (state)
      S_COLLECT: begin
        if (accept) begin
          if (!full) begin
            count_next = count + CNT_W'(1);
          end
          if (in_last) begin
            state_next = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (load) begin
          count_next = count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            state_next = S_COLLECT;
          end
        end
      end
      default: begin
        state_next = S_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_COLLECT;
      count     <= '0;
      pos       <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      // The drop flag lives for one set and clears after its last result.
      if (accept && full) begin
        dropped <= 1'b1;
      end else if (load && count == CNT_W'(1)) begin
        dropped <= 1'b0;
      end
      if (load) begin
        pos <= (count == CNT_W'(1)) ? '0 : pos + IDX_W'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
